// ===== hdl/ffba_pkg.sv =====
// Shared types and constants for the first-fit block allocator.
// Used by ffba_ctrl, ffba_dp and first_fit_block_allocator; no dependencies.
package ffba_pkg;

	// Block table geometry
	localparam int MAX_BLOCKS = 64;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

	// Field widths
	localparam int ADDR_W    = 32;
	localparam int HDR_W     = 8;
	localparam int CMD_W     = 2;
	localparam int STAT_W    = 2;
	localparam int CFG_IDX_W = 2;

	// Request commands
	localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REALLOC = 2'd2;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOMEM   = 2'd1;
	localparam logic [STAT_W-1:0] ST_UNKNOWN = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEADER     = 2'd2;

	// Table write operations
	localparam logic [2:0] WR_NONE     = 3'd0;
	localparam logic [2:0] WR_HIT_FREE = 3'd1;
	localparam logic [2:0] WR_HIT_USE  = 3'd2;
	localparam logic [2:0] WR_APPEND   = 3'd3;
	localparam logic [2:0] WR_OLD_FREE = 3'd4;

	// Result address sources
	localparam logic [1:0] RES_ZERO   = 2'd0;
	localparam logic [1:0] RES_HIT    = 2'd1;
	localparam logic [1:0] RES_APPEND = 2'd2;

	// One table entry
	typedef struct packed {
		logic              free;
		logic [ADDR_W-1:0] size;
		logic [ADDR_W-1:0] start;
	} entry_t;

	// Controller to datapath
	typedef struct packed {
		logic              load_req;
		logic              scan_clear;
		logic              scan_run;
		logic              find_mode;
		logic              save_old;
		logic [2:0]        wr_sel;
		logic              res_load;
		logic [1:0]        res_sel;
		logic [STAT_W-1:0] res_status;
		logic              res_moved;
		logic              out_push;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic hit;
		logic miss;
		logic fits;
		logic room;
	} dp_stat_t;

endpackage

// ===== hdl/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator.
// Depends on ffba_pkg, ffba_ctrl and ffba_dp.
//
//   channel  handshake              payload
//   in       in_valid / in_ready    command, request_size, block_address
//   out      out_valid / out_ready  result_address, status, moved
//   cfg      cfg_write              cfg_index, cfg_data
//
// Allocate accepts the request, reads the table one stored block at a time,
// makes the last compare, sees the miss, appends, and loads the output register
// once it has drained. Free skips the append.
// Reallocate that moves the block scans the table twice. A hit ends the scan early.
// Reset empties the table at once (the entry count goes to zero); no clearing pass.
// A waiting result does not block the next request; only its completion waits.
module first_fit_block_allocator import ffba_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [CMD_W-1:0]     command,
	input  logic [ADDR_W-1:0]    request_size,
	input  logic [ADDR_W-1:0]    block_address,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ADDR_W-1:0]    result_address,
	output logic [STAT_W-1:0]    status,
	output logic                 moved
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	ffba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	ffba_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.request_size   (request_size),
		.block_address  (block_address),
		.cmd            (dp_cmd),
		.stat           (dp_stat),
		.result_address (result_address),
		.status         (status),
		.moved          (moved)
	);

	// An accepted request leaves the block busy: in_ready is low right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while previous one still in progress");

	// Scan never reports hit and miss together
	a_hit_miss_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(dp_stat.hit && dp_stat.miss))
		else $error("scan hit and miss at once");

	// Table writes only happen while a request is in progress
	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(dp_cmd.wr_sel != WR_NONE) |-> !in_ready)
		else $error("table write while idle");

	// A result is pushed only once per request: push ends in idle
	a_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.out_push |=> in_ready && !dp_cmd.out_push)
		else $error("result pushed twice");

endmodule

// ===== hdl/ffba_ctrl.sv =====
// Request sequencer of the first-fit block allocator.
// Depends on ffba_pkg; drives ffba_dp through dp_cmd_t and reads dp_stat_t.
module ffba_ctrl import ffba_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [CMD_W-1:0] command,
	output logic             out_valid,
	input  logic             out_ready,
	input  dp_stat_t         stat,
	output dp_cmd_t          cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN     = 3'd1;
	localparam logic [2:0] S_APPEND   = 3'd2;
	localparam logic [2:0] S_FREE_OLD = 3'd3;
	localparam logic [2:0] S_DONE     = 3'd4;

	logic [2:0]       state_q, state_d;
	logic [CMD_W-1:0] cmd_q;
	logic             find_q, find_d;
	logic             out_valid_q;
	logic             is_realloc;

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign is_realloc = (cmd_q == CMD_REALLOC);

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		find_d  = find_q;
		cmd     = '0;
		cmd.find_mode = find_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req   = 1'b1;
					cmd.scan_clear = 1'b1;
					if (command == CMD_ALLOC) begin
						find_d  = 1'b0;
						state_d = S_SCAN;
					end else if (command == CMD_FREE || command == CMD_REALLOC) begin
						find_d  = 1'b1;
						state_d = S_SCAN;
					end else begin
						// unknown command: empty ok result
						cmd.res_load   = 1'b1;
						cmd.res_sel    = RES_ZERO;
						cmd.res_status = ST_OK;
						state_d        = S_DONE;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.hit) begin
					if (!find_q) begin
						// first fit found: mark used and grant it
						cmd.wr_sel     = WR_HIT_USE;
						cmd.res_load   = 1'b1;
						cmd.res_sel    = RES_HIT;
						cmd.res_status = ST_OK;
						cmd.res_moved  = is_realloc;
						state_d        = is_realloc ? S_FREE_OLD : S_DONE;
					end else if (!is_realloc) begin
						cmd.wr_sel     = WR_HIT_FREE;
						cmd.res_load   = 1'b1;
						cmd.res_sel    = RES_ZERO;
						cmd.res_status = ST_OK;
						state_d        = S_DONE;
					end else if (stat.fits) begin
						// block already large enough: keep it
						cmd.res_load   = 1'b1;
						cmd.res_sel    = RES_HIT;
						cmd.res_status = ST_OK;
						state_d        = S_DONE;
					end else begin
						// remember the old block, rescan for a fit
						cmd.save_old   = 1'b1;
						cmd.scan_clear = 1'b1;
						find_d         = 1'b0;
					end
				end else if (stat.miss) begin
					if (!find_q) begin
						state_d = S_APPEND;
					end else begin
						cmd.res_load   = 1'b1;
						cmd.res_sel    = RES_ZERO;
						cmd.res_status = ST_UNKNOWN;
						state_d        = S_DONE;
					end
				end
			end
			S_APPEND: begin
				cmd.res_load = 1'b1;
				if (stat.room) begin
					cmd.wr_sel     = WR_APPEND;
					cmd.res_sel    = RES_APPEND;
					cmd.res_status = ST_OK;
					cmd.res_moved  = is_realloc;
					state_d        = is_realloc ? S_FREE_OLD : S_DONE;
				end else begin
					cmd.res_sel    = RES_ZERO;
					cmd.res_status = ST_NOMEM;
					state_d        = S_DONE;
				end
			end
			S_FREE_OLD: begin
				cmd.wr_sel = WR_OLD_FREE;
				state_d    = S_DONE;
			end
			S_DONE: begin
				// wait for the output register to drain
				if (!out_valid_q || out_ready) begin
					cmd.out_push = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State, request command, scan mode and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cmd_q       <= CMD_ALLOC;
			find_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			find_q  <= find_d;
			if (cmd.load_req) begin
				cmd_q <= command;
			end
			if (cmd.out_push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/ffba_dp.sv =====
// Datapath of the first-fit block allocator: block table memory, scan
// pipeline, heap registers and result registers. Depends on ffba_pkg.
module ffba_dp import ffba_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  logic [ADDR_W-1:0]    request_size,
	input  logic [ADDR_W-1:0]    block_address,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	output logic [ADDR_W-1:0]    result_address,
	output logic [STAT_W-1:0]    status,
	output logic                 moved
);

	// Block table
	entry_t entry_mem [MAX_BLOCKS];

	// Heap registers; used_q tracks break - base
	logic [ADDR_W-1:0] limit_q, break_q, used_q;
	logic [HDR_W-1:0]  header_q;
	logic [CNT_W-1:0]  count_q;

	// Request registers
	logic [ADDR_W-1:0] size_q, addr_q;
	logic [ADDR_W:0]   need_q;

	// Scan pipeline
	logic [CNT_W-1:0] rd_ptr_q;
	logic             rv_s1;
	logic [IDX_W-1:0] idx_s1;
	entry_t           rd_s1;
	logic             rd_en;

	// Old block of a reallocate
	logic [IDX_W-1:0]  old_idx_q;
	logic [ADDR_W-1:0] old_size_q;

	// Pending and delivered result
	logic [ADDR_W-1:0] res_addr_q, out_addr_q;
	logic [STAT_W-1:0] res_status_q, out_status_q;
	logic              res_moved_q, out_moved_q;

	logic [ADDR_W-1:0] new_start;
	logic [ADDR_W+1:0] total;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_data;
	logic [ADDR_W-1:0] res_addr_d;

	assign new_start = break_q + {{(ADDR_W-HDR_W){1'b0}}, header_q};
	assign total     = {2'b00, used_q} + {1'b0, need_q};
	assign rd_en     = cmd.scan_run && !cmd.scan_clear && (rd_ptr_q < count_q);

	// Entry compare and append room check
	always_comb begin
		stat.fits = (rd_s1.size >= size_q);
		if (cmd.find_mode) begin
			stat.hit = rv_s1 && (rd_s1.start == addr_q);
		end else begin
			stat.hit = rv_s1 && rd_s1.free && stat.fits;
		end
		stat.miss = !rv_s1 && (rd_ptr_q >= count_q);
		stat.room = (count_q != CNT_W'(MAX_BLOCKS)) && (total <= {2'b00, limit_q});
	end

	// Table write selection
	always_comb begin
		wr_en   = 1'b1;
		wr_addr = idx_s1;
		wr_data = rd_s1;
		case (cmd.wr_sel)
			WR_HIT_FREE: begin
				wr_data.free = 1'b1;
			end
			WR_HIT_USE: begin
				wr_data.free = 1'b0;
			end
			WR_APPEND: begin
				wr_addr       = count_q[IDX_W-1:0];
				wr_data.free  = 1'b0;
				wr_data.size  = size_q;
				wr_data.start = new_start;
			end
			WR_OLD_FREE: begin
				wr_addr       = old_idx_q;
				wr_data.free  = 1'b1;
				wr_data.size  = old_size_q;
				wr_data.start = addr_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// Result address source
	always_comb begin
		case (cmd.res_sel)
			RES_HIT:    res_addr_d = rd_s1.start;
			RES_APPEND: res_addr_d = new_start;
			default:    res_addr_d = '0;
		endcase
	end

	// Table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			entry_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_s1  <= entry_mem[rd_ptr_q[IDX_W-1:0]];
			idx_s1 <= rd_ptr_q[IDX_W-1:0];
		end
	end

	// Scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			rv_s1    <= 1'b0;
		end else if (cmd.scan_clear) begin
			rd_ptr_q <= '0;
			rv_s1    <= 1'b0;
		end else if (cmd.scan_run) begin
			rv_s1 <= rd_en;
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + CNT_W'(1);
			end
		end
	end

	// Configuration and heap state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= ADDR_W'(1048576);
			header_q <= HDR_W'(32);
			break_q  <= '0;
			used_q   <= '0;
			count_q  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_HEAP_BASE: begin
					break_q <= cfg_data;
					used_q  <= '0;
					count_q <= '0;
				end
				REG_HEAP_LIMIT: limit_q  <= cfg_data;
				REG_HEADER:     header_q <= cfg_data[HDR_W-1:0];
				default: ;
			endcase
		end else if (cmd.wr_sel == WR_APPEND) begin
			count_q <= count_q + CNT_W'(1);
			break_q <= break_q + need_q[ADDR_W-1:0];
			used_q  <= used_q + need_q[ADDR_W-1:0];
		end
	end

	// Request, old block and result payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			size_q <= request_size;
			addr_q <= block_address;
			need_q <= {1'b0, request_size} + {{(ADDR_W+1-HDR_W){1'b0}}, header_q};
		end
		if (cmd.save_old) begin
			old_idx_q  <= idx_s1;
			old_size_q <= rd_s1.size;
		end
		if (cmd.res_load) begin
			res_addr_q   <= res_addr_d;
			res_status_q <= cmd.res_status;
			res_moved_q  <= cmd.res_moved;
		end
		if (cmd.out_push) begin
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
			out_moved_q  <= res_moved_q;
		end
	end

	assign result_address = out_addr_q;
	assign status         = out_status_q;
	assign moved          = out_moved_q;

endmodule
